// ===== rtl/core/hmrt_pkg.sv =====
// types and constants shared by the host message range table core
`timescale 1ns / 1ps
`default_nettype none
package hmrt_pkg;

  localparam int SLOT_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_FIND    = 3'd3;
  localparam logic [2:0] OP_SETOPEN = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_BADARG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELSE_MSG   = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        direction;
    logic [31:0] host;
    logic [7:0]  msg_low;
    logic [7:0]  msg_high;
    logic [15:0] owner_id;
    logic [3:0]  entry_index;
    logic        open_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_index;
    logic [15:0] result_owner;
    logic        used_default;
  } resp_t;

  // word walking down the cell chain with what it has gathered so far
  typedef struct packed {
    logic              valid;
    req_t              req;
    logic [SLOT_W-1:0] dslot;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [15:0]       hit_owner;
    logic              reject;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [15:0]       downer;
  } tok_t;

  typedef struct packed {
    logic              we;
    logic              dir;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       host;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [15:0]       owner;
    logic              open;
  } commit_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/hmrt_chan_if.sv =====
// valid/ready channel carrying one payload word
`timescale 1ns / 1ps
`default_nettype none
interface hmrt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hmrt_cell.sv =====
// one table cell: a read slot and a write slot, checked as the word passes
`timescale 1ns / 1ps
`default_nettype none
module hmrt_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hmrt_pkg::tok_t    tok_i,
  input  wire hmrt_pkg::commit_t commit_i,
  output hmrt_pkg::tok_t         tok_o
);
  import hmrt_pkg::*;

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

  logic [31:0] host_r [2];
  logic [31:0] host_nxt [2];
  logic [7:0]  lo_r [2];
  logic [7:0]  lo_nxt [2];
  logic [7:0]  hi_r [2];
  logic [7:0]  hi_nxt [2];
  logic [15:0] own_r [2];
  logic [15:0] own_nxt [2];
  logic        open_r [2];
  logic        open_nxt [2];
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic        d;
  logic [31:0] s_host;
  logic [7:0]  s_lo;
  logic [7:0]  s_hi;
  logic [15:0] s_own;
  logic        s_open;
  logic        used;
  logic        ei_hit;
  logic        host_ok;

  always_comb begin
    d       = tok_i.req.direction;
    s_host  = host_r[d];
    s_lo    = lo_r[d];
    s_hi    = hi_r[d];
    s_own   = own_r[d];
    s_open  = open_r[d];
    used    = (s_own != 16'd0);
    ei_hit  = (SLOT_W'(tok_i.req.entry_index) == MY_IDX);
    host_ok = (s_host == tok_i.req.host) || (s_host == 32'd0);

    host_nxt = host_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    own_nxt  = own_r;
    open_nxt = open_r;
    tok_nxt  = tok_i;

    if (tok_i.valid) begin
      if (tok_i.dslot == MY_IDX) begin
        tok_nxt.downer = own_r[0];
      end
      unique case (tok_i.req.opcode)
        OP_INSERT: begin
          if (used) begin
            if ((s_host == tok_i.req.host && s_lo == tok_i.req.msg_low &&
                 s_hi == tok_i.req.msg_high) ||
                ((host_ok || tok_i.req.host == 32'd0) &&
                 s_lo <= tok_i.req.msg_high && s_hi >= tok_i.req.msg_low)) begin
              tok_nxt.reject = 1'b1;
            end
          end else if (!tok_i.free_found) begin
            tok_nxt.free_found = 1'b1;
            tok_nxt.free_idx   = MY_IDX;
          end
        end
        OP_REMOVE: begin
          if (ei_hit) begin
            tok_nxt.hit_owner = s_own;
            own_nxt[d]        = 16'd0;
          end
        end
        OP_LOOKUP: begin
          if (!tok_i.hit && used && s_open && host_ok &&
              s_lo <= tok_i.req.msg_low && s_hi >= tok_i.req.msg_low) begin
            tok_nxt.hit       = 1'b1;
            tok_nxt.hit_idx   = MY_IDX;
            tok_nxt.hit_owner = s_own;
          end
        end
        OP_FIND: begin
          if (!tok_i.hit && s_own == tok_i.req.owner_id) begin
            tok_nxt.hit     = 1'b1;
            tok_nxt.hit_idx = MY_IDX;
          end
        end
        OP_SETOPEN: begin
          if (ei_hit && used) begin
            tok_nxt.hit       = 1'b1;
            tok_nxt.hit_owner = s_own;
            open_nxt[d]       = tok_i.req.open_flag;
          end
        end
        default: begin
        end
      endcase
    end

    if (commit_i.we && commit_i.idx == MY_IDX) begin
      host_nxt[commit_i.dir] = commit_i.host;
      lo_nxt[commit_i.dir]   = commit_i.lo;
      hi_nxt[commit_i.dir]   = commit_i.hi;
      own_nxt[commit_i.dir]  = commit_i.owner;
      open_nxt[commit_i.dir] = commit_i.open;
    end
  end

  always_ff @(posedge clk) begin
    host_r <= host_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    if (!rst_n) begin
      own_r       <= '{default: 16'd0};
      open_r      <= '{default: 1'b0};
      tok_r.valid <= 1'b0;
    end else begin
      own_r  <= own_nxt;
      open_r <= open_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ===== rtl/core/hmrt_ctrl.sv =====
// sequencer: launches a word down the chain, decodes the answer, commits inserts
`timescale 1ns / 1ps
`default_nettype none
module hmrt_ctrl #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  hmrt_chan_if.sink                           in_chan,
  hmrt_chan_if.source                         out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [hmrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hmrt_pkg::CFG_W-1:0]     cfg_wdata,
  output hmrt_pkg::tok_t                      tok_launch,
  input  wire hmrt_pkg::tok_t                 tok_last,
  output hmrt_pkg::commit_t                   commit
);
  import hmrt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  ctrl_state_t       state_r, state_nxt;
  tok_t              launch_r, launch_nxt;
  tok_t              fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;
  resp_t             resp_r, resp_nxt;
  commit_t           commit_r, commit_nxt;
  logic              dv_r, dv_nxt;
  logic [IDX_W-1:0]  dslot_r, dslot_nxt;
  logic [7:0]        low_limit_r;
  logic [7:0]        high_limit_r;
  logic [7:0]        else_msg_r;

  logic              ei_bad;
  req_t              rq;

  always_comb begin
    rq     = fin_r.req;
    ei_bad = (32'(rq.entry_index) >= 32'(TABLE_ENTRIES));

    state_nxt        = state_r;
    launch_nxt       = launch_r;
    launch_nxt.valid = 1'b0;
    fin_nxt          = fin_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    resp_nxt         = resp_r;
    commit_nxt       = commit_r;
    commit_nxt.we    = 1'b0;
    dv_nxt           = dv_r;
    dslot_nxt        = dslot_r;

    unique case (state_r)
      CS_IDLE: begin
        if (in_chan.valid) begin
          launch_nxt       = '0;
          launch_nxt.valid = 1'b1;
          launch_nxt.req   = in_chan.data;
          launch_nxt.dslot = SLOT_W'(dslot_r);
          state_nxt        = CS_SCAN;
        end
      end
      CS_SCAN: begin
        if (tok_last.valid) begin
          fin_nxt   = tok_last;
          state_nxt = CS_FINISH;
        end
      end
      CS_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          resp_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = CS_IDLE;
          unique case (rq.opcode)
            OP_INSERT: begin
              if (rq.owner_id == 16'd0) begin
                resp_nxt.status = ST_BADARG;
              end else if (rq.msg_low < low_limit_r || rq.msg_high > high_limit_r ||
                           fin_r.reject) begin
                resp_nxt.status = ST_REJECT;
              end else if (!fin_r.free_found) begin
                resp_nxt.status = ST_FULL;
              end else begin
                resp_nxt.status       = ST_OK;
                resp_nxt.result_index = 4'(fin_r.free_idx);
                resp_nxt.result_owner = rq.owner_id;
                commit_nxt.we    = 1'b1;
                commit_nxt.dir   = rq.direction;
                commit_nxt.idx   = fin_r.free_idx;
                commit_nxt.host  = rq.host;
                commit_nxt.lo    = rq.msg_low;
                commit_nxt.hi    = rq.msg_high;
                commit_nxt.owner = rq.owner_id;
                commit_nxt.open  = rq.open_flag;
                if (!rq.direction && rq.host == 32'd0 && rq.msg_low == rq.msg_high &&
                    rq.msg_low == else_msg_r) begin
                  dv_nxt    = 1'b1;
                  dslot_nxt = IDX_W'(fin_r.free_idx);
                end
              end
            end
            OP_REMOVE: begin
              if (ei_bad) begin
                resp_nxt.status = ST_BADARG;
              end else begin
                resp_nxt.status       = ST_OK;
                resp_nxt.result_index = rq.entry_index;
                resp_nxt.result_owner = fin_r.hit_owner;
                if (!rq.direction && dv_r &&
                    32'(dslot_r) == 32'(rq.entry_index)) begin
                  dv_nxt    = 1'b0;
                  dslot_nxt = '0;
                end
              end
            end
            OP_LOOKUP: begin
              if (rq.msg_low < low_limit_r) begin
                resp_nxt.status = ST_MISS;
              end else if (fin_r.hit) begin
                resp_nxt.status       = ST_OK;
                resp_nxt.result_index = 4'(fin_r.hit_idx);
                resp_nxt.result_owner = fin_r.hit_owner;
              end else if (!rq.direction && dv_r) begin
                resp_nxt.status       = ST_OK;
                resp_nxt.result_index = 4'(dslot_r);
                resp_nxt.result_owner = fin_r.downer;
                resp_nxt.used_default = 1'b1;
              end else begin
                resp_nxt.status = ST_MISS;
              end
            end
            OP_FIND: begin
              if (fin_r.hit) begin
                resp_nxt.status       = ST_OK;
                resp_nxt.result_index = 4'(fin_r.hit_idx);
                resp_nxt.result_owner = rq.owner_id;
              end else begin
                resp_nxt.status = ST_MISS;
              end
            end
            OP_SETOPEN: begin
              if (ei_bad) begin
                resp_nxt.status = ST_BADARG;
              end else if (fin_r.hit) begin
                resp_nxt.status       = ST_OK;
                resp_nxt.result_index = rq.entry_index;
                resp_nxt.result_owner = fin_r.hit_owner;
              end else begin
                resp_nxt.status = ST_MISS;
              end
            end
            default: begin
              resp_nxt.status = ST_BADARG;
            end
          endcase
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    fin_r  <= fin_nxt;
    resp_r <= resp_nxt;
    if (!rst_n) begin
      state_r        <= CS_IDLE;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
      commit_r.we    <= 1'b0;
      dv_r           <= 1'b0;
      dslot_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      commit_r    <= commit_nxt;
      dv_r        <= dv_nxt;
      dslot_r     <= dslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= 8'd0;
      high_limit_r <= 8'd255;
      else_msg_r   <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_LIMIT:  low_limit_r  <= cfg_wdata;
        CFG_HIGH_LIMIT: high_limit_r <= cfg_wdata;
        CFG_ELSE_MSG:   else_msg_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_chan.ready  = (state_r == CS_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = resp_r;
  assign tok_launch     = launch_r;
  assign commit         = commit_r;

endmodule
`default_nettype wire

// ===== rtl/core/host_message_range_table_core.sv =====
// Read and write claim tables kept in a chain of TABLE_ENTRIES cells, each cell holding one
// read slot and one write slot. A request word is taken when the core is idle, walks the
// chain one cell per cycle gathering overlap, free-slot and match information, and is
// decoded at the end; an insert is then written into its slot by a broadcast commit. No new
// word is taken until the last one has walked the whole chain and its result has been
// placed in the output register, which may wait for the receiver to take the one before.
// The result sits in an output register until taken. Configuration writes are applied at once.
`timescale 1ns / 1ps
`default_nettype none
module host_message_range_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  hmrt_chan_if.sink                           in_chan,
  hmrt_chan_if.source                         out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [hmrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hmrt_pkg::CFG_W-1:0]     cfg_wdata
);
  import hmrt_pkg::*;

  tok_t    chain [TABLE_ENTRIES+1];
  commit_t commit;

  hmrt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tok_launch (chain[0]),
    .tok_last   (chain[TABLE_ENTRIES]),
    .commit     (commit)
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    hmrt_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (chain[g]),
      .commit_i (commit),
      .tok_o    (chain[g+1])
    );
  end

endmodule
`default_nettype wire

// ===== dv/hmrt_checker.sv =====
// watches both channels, predicts every result of the claim tables and compares
`timescale 1ns / 1ps
module hmrt_checker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  hmrt_chan_if                                req_mon,
  hmrt_chan_if                                resp_mon,
  input  wire logic                           cfg_we,
  input  wire logic [hmrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hmrt_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                  errors,
  output int                                  outstanding
);
  import hmrt_pkg::*;

  logic [31:0] t_host  [2][TABLE_ENTRIES];
  logic [7:0]  t_low   [2][TABLE_ENTRIES];
  logic [7:0]  t_high  [2][TABLE_ENTRIES];
  logic [15:0] t_owner [2][TABLE_ENTRIES];
  logic        t_open  [2][TABLE_ENTRIES];
  logic        dflt_valid;
  logic [3:0]  dflt_slot;
  logic [7:0]  lim_low, lim_high, else_msg;

  resp_t expected_resp_q[$];

  function automatic void clear_tables();
    for (int d = 0; d < 2; d++) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        t_host[d][i]  = '0;
        t_low[d][i]   = '0;
        t_high[d][i]  = '0;
        t_owner[d][i] = '0;
        t_open[d][i]  = 1'b0;
      end
    end
    dflt_valid = 1'b0;
    dflt_slot  = '0;
    lim_low    = 8'd0;
    lim_high   = 8'd255;
    else_msg   = 8'd0;
  endfunction

  function automatic resp_t claim_table_answer(input req_t w);
    resp_t r;
    int    d;
    int    free_slot;
    logic  clash;
    r = '0;
    r.status = ST_BADARG;
    d = int'(w.direction);
    case (w.opcode)
      OP_INSERT: begin
        if (w.owner_id != 16'd0) begin
          if (w.msg_low < lim_low || w.msg_high > lim_high) begin
            r.status = ST_REJECT;
          end else begin
            clash = 1'b0;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (t_owner[d][i] != 16'd0) begin
                if (t_host[d][i] == w.host && t_low[d][i] == w.msg_low &&
                    t_high[d][i] == w.msg_high)
                  clash = 1'b1;
                if ((t_host[d][i] == w.host || t_host[d][i] == 32'd0 || w.host == 32'd0) &&
                    t_low[d][i] <= w.msg_high && t_high[d][i] >= w.msg_low)
                  clash = 1'b1;
              end else if (free_slot < 0) begin
                free_slot = i;
              end
            end
            if (clash) begin
              r.status = ST_REJECT;
            end else if (free_slot < 0) begin
              r.status = ST_FULL;
            end else begin
              t_host[d][free_slot]  = w.host;
              t_low[d][free_slot]   = w.msg_low;
              t_high[d][free_slot]  = w.msg_high;
              t_owner[d][free_slot] = w.owner_id;
              t_open[d][free_slot]  = w.open_flag;
              if (d == 0 && w.host == 32'd0 && w.msg_low == w.msg_high &&
                  w.msg_low == else_msg) begin
                dflt_valid = 1'b1;
                dflt_slot  = 4'(free_slot);
              end
              r.status       = ST_OK;
              r.result_index = 4'(free_slot);
              r.result_owner = w.owner_id;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (int'(w.entry_index) < TABLE_ENTRIES) begin
          r.status       = ST_OK;
          r.result_index = w.entry_index;
          r.result_owner = t_owner[d][w.entry_index];
          if (d == 0 && dflt_valid && dflt_slot == w.entry_index) begin
            dflt_valid = 1'b0;
            dflt_slot  = '0;
          end
          t_owner[d][w.entry_index] = 16'd0;
        end
      end
      OP_LOOKUP: begin
        r.status = ST_MISS;
        if (w.msg_low >= lim_low) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r.status == ST_MISS && t_owner[d][i] != 16'd0 && t_open[d][i] &&
                (t_host[d][i] == w.host || t_host[d][i] == 32'd0) &&
                t_low[d][i] <= w.msg_low && t_high[d][i] >= w.msg_low) begin
              r.status       = ST_OK;
              r.result_index = 4'(i);
              r.result_owner = t_owner[d][i];
            end
          end
          if (r.status == ST_MISS && d == 0 && dflt_valid) begin
            r.status       = ST_OK;
            r.result_index = dflt_slot;
            r.result_owner = t_owner[0][dflt_slot];
            r.used_default = 1'b1;
          end
        end
      end
      OP_FIND: begin
        r.status = ST_MISS;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (r.status == ST_MISS && t_owner[d][i] == w.owner_id) begin
            r.status       = ST_OK;
            r.result_index = 4'(i);
            r.result_owner = w.owner_id;
          end
        end
      end
      OP_SETOPEN: begin
        if (int'(w.entry_index) < TABLE_ENTRIES) begin
          if (t_owner[d][w.entry_index] == 16'd0) begin
            r.status = ST_MISS;
          end else begin
            t_open[d][w.entry_index] = w.open_flag;
            r.status       = ST_OK;
            r.result_index = w.entry_index;
            r.result_owner = t_owner[d][w.entry_index];
          end
        end
      end
      default: r.status = ST_BADARG;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    resp_t got;
    if (!rst_n) begin
      clear_tables();
      expected_resp_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW_LIMIT:  lim_low  = cfg_wdata;
          CFG_HIGH_LIMIT: lim_high = cfg_wdata;
          CFG_ELSE_MSG:   else_msg = cfg_wdata;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        expected_resp_q.push_back(claim_table_answer(req_mon.data));
      if (resp_mon.valid && resp_mon.ready) begin
        got = resp_mon.data;
        if (expected_resp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: status %0d index %0d owner %h default %0d",
                   $time, got.status, got.result_index, got.result_owner, got.used_default);
        end else begin
          want = expected_resp_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected status %0d index %0d owner %h default %0d",
                     $time, want.status, want.result_index, want.result_owner,
                     want.used_default);
            $display("%0t:           got status %0d index %0d owner %h default %0d",
                     $time, got.status, got.result_index, got.result_owner,
                     got.used_default);
          end
        end
      end
    end
    outstanding = expected_resp_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// top of the claim table testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps
module tb;
  import hmrt_pkg::*;

  localparam int         ENTRIES     = 16;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         LONG_HOLD   = 300;
  localparam logic [2:0] OP_RSVD_LO  = OP_SETOPEN + 3'd1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int errors;
  int outstanding;
  int cycles = 0;
  int hold_asks = 0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;

  logic [7:0]  cur_low  = 8'd0;
  logic [7:0]  cur_high = 8'd255;
  logic [7:0]  cur_else = 8'd0;
  logic [15:0] seen_owners[$];

  hmrt_chan_if #(.payload_t(req_t))  req_ch ();
  hmrt_chan_if #(.payload_t(resp_t)) resp_ch ();

  host_message_range_table_core #(.TABLE_ENTRIES(ENTRIES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_ch.sink),
    .out_chan  (resp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hmrt_checker #(.TABLE_ENTRIES(ENTRIES)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .resp_mon    (resp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold on request
  initial begin
    int stall;
    int hold_seen;
    stall = 0;
    hold_seen = 0;
    resp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        stall = LONG_HOLD;
      end else if (stall == 0 && rx_idle_en && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall > 0) begin
        resp_ch.ready <= 1'b0;
        stall--;
      end else begin
        resp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic req_t mk(input logic [2:0] op, input logic dir, input logic [31:0] host,
                              input logic [7:0] lo, input logic [7:0] hi,
                              input logic [15:0] owner, input logic [3:0] idx,
                              input logic open);
    req_t w;
    w.opcode      = op;
    w.direction   = dir;
    w.host        = host;
    w.msg_low     = lo;
    w.msg_high    = hi;
    w.owner_id    = owner;
    w.entry_index = idx;
    w.open_flag   = open;
    return w;
  endfunction

  function automatic logic [31:0] pick_host();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'hA5A5_5A5A;
      4: return 32'h8000_0000;
      5: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // message number, mostly from a narrow window at the low limit, so ranges collide
  function automatic logic [7:0] pick_msg();
    int win;
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    win = int'(cur_high) - int'(cur_low);
    if (win > 40) win = 40;
    return 8'(int'(cur_low) + $urandom_range(0, win));
  endfunction

  function automatic req_t random_word();
    req_t w;
    int   pick;
    int   span;
    w.direction   = 1'($urandom_range(0, 1));
    w.host        = pick_host();
    w.msg_low     = pick_msg();
    span          = $urandom_range(0, 6);
    w.msg_high    = (int'(w.msg_low) + span > 255) ? 8'd255 : 8'(int'(w.msg_low) + span);
    w.owner_id    = 16'($urandom_range(1, 65535));
    w.entry_index = 4'($urandom);
    w.open_flag   = $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      w.opcode = OP_INSERT;
      case ($urandom_range(0, 19))
        0: w.owner_id = 16'd0;
        1, 2: begin
          w.msg_low  = 8'($urandom);
          w.msg_high = 8'($urandom);
        end
        3: begin
          w.direction = 1'b0;
          w.host      = 32'd0;
          w.msg_low   = cur_else;
          w.msg_high  = cur_else;
        end
        default: ;
      endcase
      seen_owners.push_back(w.owner_id);
      if (seen_owners.size() > 32) void'(seen_owners.pop_front());
    end else if (pick < 54) begin
      w.opcode = OP_REMOVE;
    end else if (pick < 80) begin
      w.opcode = OP_LOOKUP;
    end else if (pick < 90) begin
      w.opcode = OP_FIND;
      case ($urandom_range(0, 9))
        0: w.owner_id = 16'd0;
        1, 2, 3: ;
        default: if (seen_owners.size() > 0)
          w.owner_id = seen_owners[$urandom_range(0, seen_owners.size() - 1)];
      endcase
    end else if (pick < 98) begin
      w.opcode = OP_SETOPEN;
    end else begin
      w.opcode = OP_RSVD_LO + 3'($urandom_range(0, 2));
    end
    return w;
  endfunction

  task automatic send_word(input req_t w);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] el);
    cur_low  = lo;
    cur_high = hi;
    cur_else = el;
    write_reg(CFG_LOW_LIMIT, lo);
    write_reg(CFG_HIGH_LIMIT, hi);
    write_reg(CFG_ELSE_MSG, el);
  endtask

  task automatic send_paced(input req_t w);
    send_word(w);
    if (tx_idle_en && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 19));
  endtask

  task automatic directed_words();
    send_paced(mk(OP_INSERT, 1'b0, 32'h0000_1234, 8'd5, 8'd9, 16'd0, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b0, 32'h0, 8'd0, 8'd0, 16'hFFFF, 4'd0, 1'b0));
    send_paced(mk(OP_LOOKUP, 1'b0, 32'h1234_5678, 8'd5, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_INSERT, 1'b0, 32'hFFFF_FFFF, 8'd10, 8'd20, 16'h0001, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b0, 32'hFFFF_FFFF, 8'd10, 8'd20, 16'h0002, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b0, 32'hFFFF_FFFF, 8'd15, 8'd30, 16'h0002, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b0, 32'h0000_0005, 8'd15, 8'd30, 16'h0003, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b1, 32'h0000_0007, 8'd200, 8'd100, 16'h0004, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b1, 32'h0000_0007, 8'd200, 8'd100, 16'h0005, 4'd0, 1'b1));
    send_paced(mk(OP_INSERT, 1'b1, 32'h0, 8'd255, 8'd255, 16'h8000, 4'd0, 1'b1));
    send_paced(mk(OP_LOOKUP, 1'b0, 32'hFFFF_FFFF, 8'd12, 8'd255, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_LOOKUP, 1'b1, 32'h0000_0009, 8'd255, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_SETOPEN, 1'b0, 32'h0, 8'd0, 8'd0, 16'd0, 4'd0, 1'b1));
    send_paced(mk(OP_LOOKUP, 1'b0, 32'h0000_0009, 8'd0, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_SETOPEN, 1'b0, 32'h0, 8'd0, 8'd0, 16'd0, 4'hF, 1'b1));
    send_paced(mk(OP_FIND, 1'b0, 32'h0, 8'd0, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_FIND, 1'b1, 32'h0, 8'd0, 8'd0, 16'h8000, 4'd0, 1'b0));
    send_paced(mk(OP_FIND, 1'b0, 32'h0, 8'd0, 8'd0, 16'h4321, 4'd0, 1'b0));
    send_paced(mk(OP_REMOVE, 1'b0, 32'h0, 8'd0, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_LOOKUP, 1'b0, 32'h0000_0001, 8'd0, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_REMOVE, 1'b1, 32'h0, 8'd0, 8'd0, 16'd0, 4'hF, 1'b0));
    send_paced(mk(OP_RSVD_LO, 1'b0, 32'hFFFF_FFFF, 8'd1, 8'd2, 16'h0001, 4'd1, 1'b1));
    send_paced(mk(OP_RSVD_LO + 3'd1, 1'b1, 32'h0, 8'd0, 8'd0, 16'd0, 4'd0, 1'b0));
    send_paced(mk(OP_RSVD_LO + 3'd2, 1'b0, 32'h0, 8'd255, 8'd255, 16'hFFFF, 4'hF, 1'b1));
  endtask

  initial begin
    int n_items [7];
    logic [7:0] lo;
    logic [7:0] hi;
    n_items = '{250, 110, 110, 250, 250, 200, 200};
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    directed_words();

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: set_limits(8'd0, 8'd255, 8'd0);
        1: set_limits(8'd255, 8'd255, 8'd255);
        2: set_limits(8'd0, 8'd0, 8'd0);
        3: set_limits(8'd64, 8'd191, 8'd70);
        4: begin
          lo = 8'($urandom_range(0, 200));
          hi = 8'($urandom_range(lo, 255));
          set_limits(lo, hi, 8'($urandom_range(lo, hi)));
        end
        5: set_limits(8'd0, 8'd255, 8'd255);
        default: set_limits(8'd16, 8'd240, 8'd17);
      endcase
      // empty both tables before every odd phase so that setting starts fresh
      if (ph % 2 == 1) begin
        for (int d = 0; d < 2; d++)
          for (int i = 0; i < ENTRIES; i++)
            send_paced(mk(OP_REMOVE, 1'(d), $urandom, 8'($urandom), 8'($urandom),
                          16'($urandom), 4'(i), 1'($urandom)));
      end
      if (ph == 2) begin
        @(posedge clk);
        hold_asks++;
      end
      for (int n = 0; n < n_items[ph]; n++) begin
        if (ph == 6) begin
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end else if (n % 64 == 0) begin
          tx_idle_en = $urandom_range(0, 3) != 0;
          rx_idle_en = $urandom_range(0, 3) != 0;
        end
        send_paced(random_word());
      end
    end

    drain();
    repeat (ENTRIES + 8) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
